/* rtl/qph_pkg.sv */
// Shared types and codes for the quadratic-probe hash table unit.
package qph_pkg;

   localparam int KEY_W   = 31;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;

   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd1;
   localparam logic [STAT_W-1:0] ST_PRESENT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] occupied_count;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

/* rtl/qph_mod_reduce.sv */
// Home slot: key modulo the table size by reciprocal multiplication.
module qph_mod_reduce #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [qph_pkg::KEY_W-1:0]     key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int SHIFT = qph_pkg::KEY_W + IDX_W;
   // ceil(2^SHIFT / TABLE_SIZE) yields the exact quotient for every 31-bit key.
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam int RECIP_W = $clog2(RECIP + 64'd1);
   localparam int PROD_W  = qph_pkg::KEY_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - SHIFT;
   localparam int QD_W    = QUOT_W + IDX_W + 1;

   logic [qph_pkg::KEY_W-1:0] key_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [qph_pkg::KEY_W-1:0] qd_ff;
   logic [IDX_W-1:0]          rem_ff;
   logic                      mul_ff;
   logic                      back_ff;
   logic                      sub_ff;
   logic                      done_ff;
   logic [QUOT_W-1:0]         quot;
   logic [QD_W-1:0]           qd_full;
   logic [qph_pkg::KEY_W-1:0] diff;

   // Quotient from the reciprocal product, multiply back, subtract.
   assign quot    = prod_ff[PROD_W-1:SHIFT];
   assign qd_full = QD_W'(quot) * QD_W'(TABLE_SIZE);
   assign diff    = key_ff - qd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         back_ff <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= load;
         back_ff <= mul_ff;
         sub_ff  <= back_ff;
         done_ff <= sub_ff;
      end
      if (load) begin
         key_ff <= key;
      end
      if (mul_ff) begin
         prod_ff <= PROD_W'(key_ff) * PROD_W'(RECIP);
      end
      if (back_ff) begin
         qd_ff <= qd_full[qph_pkg::KEY_W-1:0];
      end
      if (sub_ff) begin
         rem_ff <= diff[IDX_W-1:0];
      end
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

/* rtl/quadratic_probe_hash_table_unit.sv */
// Top level of the open-addressing key table with quadratic probing.
//
// Each transfer on req_item is a search, insert or remove of a 31-bit key,
// accepted when start is high and busy is low. Exactly one result follows
// on rsp_item, marked by a one-cycle rsp_strobe; the receiver cannot stall,
// so it must take the result in that cycle. The home slot is the key modulo
// TABLE_SIZE, formed by a reciprocal multiplication. The probe sequence then
// reads one slot per cycle from the single-port slot memory: home, home+1,
// home+1+4, ... until the position leaves the table or the key is found. One
// pass collects both the matching slot and the first empty slot, so an insert
// does not probe twice. The number of probe positions read is at most about
// the cube root of 3*TABLE_SIZE, 15 for 1024 slots. The slot memory
// write-back falls in the cycle before the result, and busy drops with the
// result, so the next transfer can be taken in that cycle. After reset the
// block stays busy while it clears every slot, one per cycle.
module quadratic_probe_hash_table_unit #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qph_pkg::req_type req_item,
   output logic             rsp_strobe,
   output qph_pkg::rsp_type rsp_item
);

   localparam int IDX_W    = $clog2(TABLE_SIZE);
   localparam int POS_W    = IDX_W + 2;
   localparam int OCC_W    = $clog2(TABLE_SIZE + 1);
   localparam int SLOT_EXT = (IDX_W > qph_pkg::SLOT_W) ? IDX_W : qph_pkg::SLOT_W;
   localparam int OCC_EXT  = (OCC_W > qph_pkg::COUNT_W) ? OCC_W : qph_pkg::COUNT_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_FINISH
   } state_type;

   // Slot memory: valid bit plus key per slot.
   qph_pkg::entry_type mem [TABLE_SIZE];
   qph_pkg::entry_type rd_data_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   qph_pkg::entry_type wr_data;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   qph_pkg::req_type cmd_ff, cmd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] step_ff, step_in;
   logic [POS_W-1:0] inc_ff, inc_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] rd_slot_ff, rd_slot_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_slot_ff, hit_slot_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_slot_ff, free_slot_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   qph_pkg::rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic                hash_done;
   logic [IDX_W-1:0]    home;
   logic                match;
   logic                vacant;
   logic                in_range;
   logic [IDX_W-1:0]    slot_pick;
   logic [SLOT_EXT-1:0] slot_ext;
   logic [OCC_EXT-1:0]  occ_ext;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   qph_mod_reduce #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_reduce (
      .clock(clock),
      .reset(reset),
      .load (accept),
      .key  (req_item.key),
      .done (hash_done),
      .home (home)
   );

   // Evaluate the slot read issued in the previous cycle.
   assign match    = pend_ff && rd_data_ff.valid && (rd_data_ff.key == cmd_ff.key);
   assign vacant   = pend_ff && !rd_data_ff.valid;
   assign in_range = (pos_ff < POS_W'(TABLE_SIZE));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      inc_in        = inc_ff;
      pend_in       = 1'b0;
      rd_slot_in    = rd_slot_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      occ_in        = occ_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = '0;
      slot_pick     = '0;
      slot_ext      = '0;
      occ_ext       = '0;

      case (state_ff)
         S_CLEAR: begin
            // Empty one slot per cycle after reset.
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_item;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            // Hold until the home slot is ready, then seed the probe walk.
            if (hash_done) begin
               pos_in   = POS_W'(home);
               step_in  = POS_W'(1);
               inc_in   = POS_W'(3);
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (match) begin
               // First match along the sequence wins; drop any later read.
               hit_in      = 1'b1;
               hit_slot_in = rd_slot_ff;
               state_in    = S_FINISH;
            end else begin
               if (vacant && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = rd_slot_ff;
               end
               if (in_range) begin
                  rd_en      = 1'b1;
                  pend_in    = 1'b1;
                  rd_slot_in = pos_ff[IDX_W-1:0];
                  // Advance by (k+1)^2, kept as a running sum of odd numbers.
                  pos_in     = pos_ff + step_ff;
                  step_in    = step_ff + inc_ff;
                  inc_in     = inc_ff + POS_W'(2);
               end else if (!pend_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            rsp_in.status = qph_pkg::ST_ABSENT;
            case (cmd_ff.command)
               qph_pkg::CMD_SEARCH: begin
                  if (hit_ff) begin
                     rsp_in.status = qph_pkg::ST_OK;
                     slot_pick     = hit_slot_ff;
                  end
               end
               qph_pkg::CMD_INSERT: begin
                  if (hit_ff) begin
                     rsp_in.status = qph_pkg::ST_PRESENT;
                  end else if (!free_ff) begin
                     rsp_in.status = qph_pkg::ST_FULL;
                  end else begin
                     rsp_in.status = qph_pkg::ST_OK;
                     slot_pick     = free_slot_ff;
                     wr_en         = 1'b1;
                     wr_addr       = free_slot_ff;
                     wr_data.valid = 1'b1;
                     wr_data.key   = cmd_ff.key;
                     occ_in        = occ_ff + 1'b1;
                  end
               end
               qph_pkg::CMD_REMOVE: begin
                  if (hit_ff) begin
                     rsp_in.status = qph_pkg::ST_OK;
                     slot_pick     = hit_slot_ff;
                     wr_en         = 1'b1;
                     wr_addr       = hit_slot_ff;
                     if (occ_ff != '0) begin
                        occ_in = occ_ff - 1'b1;
                     end
                  end
               end
               default: begin
                  rsp_in.status = qph_pkg::ST_ABSENT;
               end
            endcase
            slot_ext              = SLOT_EXT'(slot_pick);
            occ_ext               = OCC_EXT'(occ_in);
            rsp_in.slot_index     = slot_ext[qph_pkg::SLOT_W-1:0];
            rsp_in.occupied_count = occ_ext[qph_pkg::COUNT_W-1:0];
            rsp_strobe_in         = 1'b1;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff       <= cmd_in;
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      inc_ff       <= inc_in;
      rd_slot_ff   <= rd_slot_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      rsp_ff       <= rsp_in;
   end

   // Single-port slot memory; reads and writes never fall in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* rtl/qph_checker.sv */
// Port-level checks for the hash table unit, bound to the top level.
module qph_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input qph_pkg::req_type req_item,
   input logic             rsp_strobe,
   input qph_pkg::rsp_type rsp_item
);

   // A transfer always starts a multi-cycle operation.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transfer");

   // A result shows only once its operation is over.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Each result lasts exactly one cycle.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held more than one cycle");

   // Failed operations report slot zero.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != qph_pkg::ST_OK) |-> (rsp_item.slot_index == '0))
      else $error("nonzero slot on failed operation");

   // A result follows only an operation that was started.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a running operation");

endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_strobe(rsp_strobe),
   .rsp_item  (rsp_item)
);

/* tb/qph_table_model_pkg.sv */
// Predictor and result checker for the quadratic-probe hash table testbench.
package qph_table_model_pkg;

   import qph_pkg::*;

   class probe_table_model #(int TABLE_SIZE = 1024);

      localparam int NO_SLOT = -1;

      bit               slot_used [TABLE_SIZE];
      logic [KEY_W-1:0] slot_key  [TABLE_SIZE];
      int unsigned      occupancy;
      rsp_type          expected_results [$];
      int unsigned      mismatches;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
         end
         occupancy  = 0;
         mismatches = 0;
      endfunction

      // Walk home, home+1, home+1+4, ... and stop before leaving the table.
      function int find_slot(input logic [KEY_W-1:0] key, input bit want_empty);
         longint unsigned pos;
         longint unsigned step;
         pos  = key % TABLE_SIZE;
         step = 0;
         while (pos < TABLE_SIZE) begin
            if (want_empty) begin
               if (!slot_used[pos])
                  return int'(pos);
            end else if (slot_used[pos] && slot_key[pos] == key) begin
               return int'(pos);
            end
            step++;
            pos += step * step;
         end
         return NO_SLOT;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Apply one accepted command to the shadow table and queue its result.
      function void note_command(input req_type item);
         rsp_type expected;
         int      hit;
         int      free_slot;
         expected.status = ST_ABSENT;
         expected.slot_index = '0;
         case (item.command)
            CMD_SEARCH: begin
               hit = find_slot(item.key, 1'b0);
               if (hit != NO_SLOT) begin
                  expected.status     = ST_OK;
                  expected.slot_index = hit[SLOT_W-1:0];
               end
            end
            CMD_INSERT: begin
               hit = find_slot(item.key, 1'b0);
               if (hit != NO_SLOT) begin
                  expected.status = ST_PRESENT;
               end else begin
                  free_slot = find_slot(item.key, 1'b1);
                  if (free_slot == NO_SLOT) begin
                     expected.status = ST_FULL;
                  end else begin
                     slot_used[free_slot] = 1'b1;
                     slot_key[free_slot]  = item.key;
                     occupancy++;
                     expected.status     = ST_OK;
                     expected.slot_index = free_slot[SLOT_W-1:0];
                  end
               end
            end
            CMD_REMOVE: begin
               hit = find_slot(item.key, 1'b0);
               if (hit != NO_SLOT) begin
                  slot_used[hit] = 1'b0;
                  slot_key[hit]  = '0;
                  if (occupancy > 0)
                     occupancy--;
                  expected.status     = ST_OK;
                  expected.slot_index = hit[SLOT_W-1:0];
               end
            end
            default: ;
         endcase
         expected.occupied_count = occupancy[COUNT_W-1:0];
         expected_results.push_back(expected);
      endfunction

      function void check_result(input rsp_type got, input longint unsigned stamp);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $display("%0d ns: unexpected result status %0d slot %0d count %0d",
                     stamp, got.status, got.slot_index, got.occupied_count);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $display("%0d ns: status expected %0d actual %0d",
                     stamp, want.status, got.status);
            mismatches++;
         end
         if (got.slot_index !== want.slot_index) begin
            $display("%0d ns: slot_index expected %0d actual %0d",
                     stamp, want.slot_index, got.slot_index);
            mismatches++;
         end
         if (got.occupied_count !== want.occupied_count) begin
            $display("%0d ns: occupied_count expected %0d actual %0d",
                     stamp, want.occupied_count, got.occupied_count);
            mismatches++;
         end
      endfunction

   endclass

endpackage

/* tb/tb_quadratic_probe_hash_table_unit.sv */
// Top-level testbench of the quadratic-probe hash table unit.
module tb_quadratic_probe_hash_table_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import qph_pkg::*;
   import qph_table_model_pkg::*;

   localparam int TABLE_SIZE  = 1024;
   localparam int ITEM_COUNT  = 1500;
   localparam int DRAIN_WAIT  = 80;         // longest probe walk plus write-back, with margin
   localparam int CYCLE_LIMIT = 1_000_000;  // clear pass plus worst-case items, several times

   // The block answers the fourth command code as absent; it has no name in the package.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_strobe;
   req_type req_item;
   rsp_type rsp_item;
   int      cycle_count = 0;

   probe_table_model #(TABLE_SIZE) table_model;

   quadratic_probe_hash_table_unit #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run; a hung block or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Take every strobed result at the edge that closes its cycle; the
   // values read here are the ones the block held during that cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         table_model.check_result(rsp_item, $time);
   end

   // Present one command and hold it until the block takes it. A transfer
   // happens at the edge where start was high and busy was low. After it,
   // optionally drop start for a random gap so idle cycles land on every
   // phase of the probe walk. Without a gap start stays high, so the next
   // call raises nothing twice in one step.
   task automatic issue_command(input req_type item, input int idle_pct);
      int gap;
      start    <= 1'b1;
      req_item <= item;
      do
         @(posedge clock);
      while (busy);
      table_model.note_command(item);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 3 * idle_pct);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Draw a key. Most keys come from a small pool homed near the top of the
   // table, where probe walks are short, so inserts collide, searches hit,
   // removes find their key and inserts run out of free probe slots. The
   // rest spread over the whole table and over all 31 key bits.
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] home;
      logic [KEY_W-1:0] upper;
      if ($urandom_range(3) == 0)
         home = KEY_W'($urandom_range(TABLE_SIZE - 1));
      else
         home = KEY_W'($urandom_range(TABLE_SIZE - 24, TABLE_SIZE - 1));
      if ($urandom_range(7) == 0)
         upper = KEY_W'($urandom);
      else
         upper = KEY_W'($urandom_range(5));
      return KEY_W'(upper * KEY_W'(TABLE_SIZE) + home);
   endfunction

   function automatic req_type random_command();
      req_type     item;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40)
         item.command = CMD_INSERT;
      else if (roll < 70)
         item.command = CMD_SEARCH;
      else if (roll < 95)
         item.command = CMD_REMOVE;
      else
         item.command = CMD_UNUSED;
      item.key = ($urandom_range(31) == 0) ? KEY_W'($urandom) : pick_key();
      return item;
   endfunction

   initial begin
      req_type directed_items [$];
      req_type item;
      int      idle_pct [4];
      int      counted;

      table_model = new();
      // Phases: no idling, heavy sender gaps, no idling again (the receiver
      // cannot stall), then moderate sender gaps.
      idle_pct = '{0, 64, 0, 33};

      // Hold reset with every input at a known value.
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty table, then collisions on home slot zero along the probe walk.
      directed_items.push_back('{CMD_SEARCH, 31'd0});
      directed_items.push_back('{CMD_REMOVE, 31'd0});
      directed_items.push_back('{CMD_INSERT, 31'd0});
      directed_items.push_back('{CMD_INSERT, 31'd0});
      directed_items.push_back('{CMD_SEARCH, 31'd0});
      directed_items.push_back('{CMD_INSERT, 31'd1024});
      directed_items.push_back('{CMD_INSERT, 31'd2048});
      directed_items.push_back('{CMD_SEARCH, 31'd2048});
      // Remove the middle key; the search must walk past the hole.
      directed_items.push_back('{CMD_REMOVE, 31'd1024});
      directed_items.push_back('{CMD_SEARCH, 31'd2048});
      directed_items.push_back('{CMD_INSERT, 31'd2048});
      // Largest key homes on the last slot, which has one probe position only.
      directed_items.push_back('{CMD_INSERT, 31'h7FFF_FFFF});
      directed_items.push_back('{CMD_INSERT, 31'h7FFF_FBFF});
      directed_items.push_back('{CMD_SEARCH, 31'h7FFF_FBFF});
      directed_items.push_back('{CMD_UNUSED, 31'h7FFF_FFFF});
      directed_items.push_back('{CMD_REMOVE, 31'h7FFF_FFFF});
      directed_items.push_back('{CMD_INSERT, 31'h7FFF_FBFF});
      directed_items.push_back('{CMD_INSERT, 31'h5555_5555});
      directed_items.push_back('{CMD_SEARCH, 31'h2AAA_AAAA});
      directed_items.push_back('{CMD_SEARCH, 31'h5555_5555});
      directed_items.push_back('{CMD_REMOVE, 31'd0});
      directed_items.push_back('{CMD_REMOVE, 31'd2048});
      directed_items.push_back('{CMD_UNUSED, 31'd0});
      foreach (directed_items[i])
         issue_command(directed_items[i], 0);

      // Random part, split over the idling phases. Ignored commands are
      // sent but do not advance the count.
      foreach (idle_pct[p]) begin
         counted = 0;
         while (counted < ITEM_COUNT / 4) begin
            item = random_command();
            issue_command(item, idle_pct[p]);
            if (item.command != CMD_UNUSED)
               counted++;
         end
      end
      start <= 1'b0;

      // Drain every outstanding result, then watch for strays.
      while (table_model.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (table_model.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
rtl/qph_pkg.sv
rtl/qph_mod_reduce.sv
rtl/quadratic_probe_hash_table_unit.sv
rtl/qph_checker.sv
tb/qph_table_model_pkg.sv
tb/tb_quadratic_probe_hash_table_unit.sv
